FILE: sv/qrm_pkg.sv
// Shared widths and types for the quaternion to rotation matrix block.
`default_nettype none
package qrm_pkg;
    localparam int IN_W      = 16;              // quaternion component width
    localparam int FRAC_W    = 14;              // output fraction bits
    localparam int OUT_W     = FRAC_W + 2;      // Q1.14 entry width
    localparam int PROD_W    = 2 * IN_W;        // signed product width
    localparam int NUM_W     = 2 * IN_W + 1;    // numerator magnitude and norm width
    localparam int REM_W     = NUM_W + 1;       // divider remainder width
    localparam int QBITS     = FRAC_W + 2;      // integer bit, fraction bits, round bit
    localparam int N_ENT     = 9;               // matrix entries
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW   = $clog2(FIFO_DEPTH);

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic [N_ENT-1:0]            neg;
        logic [N_ENT-1:0][NUM_W-1:0] mag;
        logic [NUM_W-1:0]            den;
        logic                        zero;
    } work_t;
endpackage
`default_nettype wire

FILE: sv/qrm_fifo.sv
// Short queue between the front and the back.
`default_nettype none
module qrm_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire qrm_pkg::work_t din,
    output logic               full,
    input  wire logic          pop,
    output qrm_pkg::work_t     dout,
    output logic               empty
);
    qrm_pkg::work_t mem [qrm_pkg::FIFO_DEPTH];
    logic [qrm_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [qrm_pkg::FIFO_AW:0]   count_reg;

    assign full  = (count_reg == (qrm_pkg::FIFO_AW+1)'(qrm_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

FILE: sv/qrm_front.sv
// Front: squares and cross products, then norm and entry numerators.
`default_nettype none
module qrm_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [qrm_pkg::IN_W-1:0]  q_w,
    input  wire logic signed [qrm_pkg::IN_W-1:0]  q_x,
    input  wire logic signed [qrm_pkg::IN_W-1:0]  q_y,
    input  wire logic signed [qrm_pkg::IN_W-1:0]  q_z,
    output logic                                  push,
    output qrm_pkg::work_t                        work,
    input  wire logic                             full
);
    localparam int PW = qrm_pkg::PROD_W;
    localparam int NW = qrm_pkg::NUM_W;

    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic                 zero1_reg, v1_reg, v2_reg;
    qrm_pkg::work_t       work_reg, work_next;
    logic                 en;

    // off-diagonal: 2*(p +/- r), split into sign and magnitude
    function automatic logic [NW:0] off_diag(input logic signed [PW-1:0] p,
                                             input logic signed [PW-1:0] r,
                                             input logic sub);
        logic signed [NW-1:0] s;
        logic [NW-1:0]        a;
        s = sub ? (NW'(p) - NW'(r)) : (NW'(p) + NW'(r));
        a = s[NW-1] ? NW'(-s) : NW'(s);
        return {s[NW-1], a[NW-2:0], 1'b0};
    endfunction

    // diagonal: (a0 + a1) - (b0 + b1), sign and magnitude
    function automatic logic [NW:0] diag(input logic signed [PW-1:0] a0,
                                         input logic signed [PW-1:0] a1,
                                         input logic signed [PW-1:0] b0,
                                         input logic signed [PW-1:0] b1);
        logic signed [NW-1:0] d;
        d = NW'(a0) + NW'(a1) - NW'(b0) - NW'(b1);
        return {d[NW-1], d[NW-1] ? NW'(-d) : NW'(d)};
    endfunction

    assign en       = !v2_reg || !full;
    assign in_ready = en;
    assign push     = v2_reg && !full;
    assign work     = work_reg;

    // numerators and norm
    always_comb begin
        logic [NW:0] e [qrm_pkg::N_ENT];
        e[0] = diag(ww_reg, xx_reg, yy_reg, zz_reg);
        e[1] = off_diag(xy_reg, wz_reg, 1'b1);
        e[2] = off_diag(xz_reg, wy_reg, 1'b0);
        e[3] = off_diag(xy_reg, wz_reg, 1'b0);
        e[4] = diag(ww_reg, yy_reg, xx_reg, zz_reg);
        e[5] = off_diag(yz_reg, wx_reg, 1'b1);
        e[6] = off_diag(xz_reg, wy_reg, 1'b1);
        e[7] = off_diag(yz_reg, wx_reg, 1'b0);
        e[8] = diag(ww_reg, zz_reg, xx_reg, yy_reg);
        for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
            work_next.neg[i] = e[i][NW];
            work_next.mag[i] = e[i][NW-1:0];
        end
        work_next.den  = NW'($unsigned(ww_reg)) + NW'($unsigned(xx_reg))
                       + NW'($unsigned(yy_reg)) + NW'($unsigned(zz_reg));
        work_next.zero = zero1_reg;
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (en) begin
            ww_reg    <= q_w * q_w;
            xx_reg    <= q_x * q_x;
            yy_reg    <= q_y * q_y;
            zz_reg    <= q_z * q_z;
            xy_reg    <= q_x * q_y;
            wz_reg    <= q_w * q_z;
            xz_reg    <= q_x * q_z;
            wy_reg    <= q_w * q_y;
            yz_reg    <= q_y * q_z;
            wx_reg    <= q_w * q_x;
            zero1_reg <= (q_w == '0) && (q_x == '0) && (q_y == '0) && (q_z == '0);
            work_reg  <= work_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end
endmodule
`default_nettype wire

FILE: sv/qrm_div.sv
// Restoring divider pipeline, one quotient bit per stage.
`default_nettype none
module qrm_div (
    input  wire logic                                         aclk,
    input  wire logic                                         en,
    input  wire logic [qrm_pkg::NUM_W-1:0]                    mag,
    input  wire logic [qrm_pkg::QBITS-1:0][qrm_pkg::NUM_W-1:0] den,
    output logic [qrm_pkg::QBITS-1:0]                         quo
);
    localparam int RW = qrm_pkg::REM_W;
    localparam int QB = qrm_pkg::QBITS;

    logic [RW-1:0] rem_reg [QB];
    logic [QB-1:0] q_reg   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [RW-1:0] t;
        logic [RW-1:0] d;
        logic [QB-1:0] qp;
        logic          ge;
        if (k == 0) begin : g_first
            assign t  = RW'(mag);
            assign qp = '0;
        end else begin : g_rest
            assign t  = {rem_reg[k-1][RW-2:0], 1'b0};
            assign qp = q_reg[k-1];
        end
        assign d  = RW'(den[k]);
        assign ge = (t >= d);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? (t - d) : t;
                q_reg[k]   <= {qp[QB-2:0], ge};
            end
        end
    end

    assign quo = q_reg[QB-1];
endmodule
`default_nettype wire

FILE: sv/qrm_back.sv
// Back: nine divider pipelines sharing the norm, then rounding and sign.
`default_nettype none
module qrm_back (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        empty,
    output logic                                             pop,
    input  wire qrm_pkg::work_t                              work,
    output logic                                             out_valid,
    input  wire logic                                        out_ready,
    output logic [qrm_pkg::N_ENT-1:0][qrm_pkg::OUT_W-1:0]    ent,
    output logic                                             zero
);
    localparam int QB = qrm_pkg::QBITS;
    localparam int NE = qrm_pkg::N_ENT;
    localparam int OW = qrm_pkg::OUT_W;

    logic                           en;
    logic [QB-1:0]                  v_reg;
    logic [qrm_pkg::NUM_W-1:0]      den_reg  [QB];
    logic [NE-1:0]                  neg_reg  [QB];
    logic                           zero_reg [QB];
    logic [QB-1:0][qrm_pkg::NUM_W-1:0] den_in;
    logic [NE-1:0][QB-1:0]          quo;
    logic                           out_valid_reg, zero_out_reg;
    logic [NE-1:0][OW-1:0]          ent_reg, ent_next;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && !empty;

    // norm seen by each divider stage
    always_comb begin
        den_in[0] = work.den;
        for (int k = 1; k < QB; k++) begin
            den_in[k] = den_reg[k-1];
        end
    end

    for (genvar i = 0; i < NE; i++) begin : g_div
        qrm_div u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (work.mag[i]),
            .den  (den_in),
            .quo  (quo[i])
        );
    end

    // side data travelling with the quotient bits
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= work.den;
            neg_reg[0]  <= work.neg;
            zero_reg[0] <= work.zero;
            for (int k = 1; k < QB; k++) begin
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    // round half away from zero, apply sign; all entries zero for a zero norm
    always_comb begin
        logic [QB:0] r;
        for (int i = 0; i < NE; i++) begin
            r = ((QB+1)'(quo[i]) + 1'b1) >> 1;
            if (zero_reg[QB-1])          ent_next[i] = '0;
            else if (neg_reg[QB-1][i])   ent_next[i] = OW'(-r);
            else                         ent_next[i] = OW'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ent_reg      <= ent_next;
            zero_out_reg <= zero_reg[QB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg         <= {v_reg[QB-2:0], pop};
            out_valid_reg <= v_reg[QB-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign ent       = ent_reg;
    assign zero      = zero_out_reg;
endmodule
`default_nettype wire

FILE: sv/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix, top level.
// Takes one quaternion (w, x, y, z) per cycle while s_ready is high, at any common
// scale, and returns the nine rotation matrix entries in signed Q1.14, each exactly
// (numerator / norm squared) rounded half away from zero. An all-zero quaternion
// gives zero entries with zero_norm set. A beat passes through two front stages
// (products, then norm and numerators), one queue slot, and sixteen divider stages
// that each settle one quotient bit, plus the output register. Sustained rate is
// one beat per cycle while m_ready is high; the four-entry queue lets the front keep
// accepting while the result side stalls, until the queue fills.
`default_nettype none
module quaternion_to_rotation_matrix (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [qrm_pkg::IN_W-1:0]  s_q_w,
    input  wire logic signed [qrm_pkg::IN_W-1:0]  s_q_x,
    input  wire logic signed [qrm_pkg::IN_W-1:0]  s_q_y,
    input  wire logic signed [qrm_pkg::IN_W-1:0]  s_q_z,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [qrm_pkg::OUT_W-1:0]      m_m00,
    output logic signed [qrm_pkg::OUT_W-1:0]      m_m01,
    output logic signed [qrm_pkg::OUT_W-1:0]      m_m02,
    output logic signed [qrm_pkg::OUT_W-1:0]      m_m10,
    output logic signed [qrm_pkg::OUT_W-1:0]      m_m11,
    output logic signed [qrm_pkg::OUT_W-1:0]      m_m12,
    output logic signed [qrm_pkg::OUT_W-1:0]      m_m20,
    output logic signed [qrm_pkg::OUT_W-1:0]      m_m21,
    output logic signed [qrm_pkg::OUT_W-1:0]      m_m22,
    output logic                                  m_zero_norm
);
    logic           push, full, pop, empty;
    qrm_pkg::work_t front_work, queue_work;
    logic [qrm_pkg::N_ENT-1:0][qrm_pkg::OUT_W-1:0] ent;

    qrm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .q_w      (s_q_w),
        .q_x      (s_q_x),
        .q_y      (s_q_y),
        .q_z      (s_q_z),
        .push     (push),
        .work     (front_work),
        .full     (full)
    );

    qrm_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (front_work),
        .full    (full),
        .pop     (pop),
        .dout    (queue_work),
        .empty   (empty)
    );

    qrm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .pop       (pop),
        .work      (queue_work),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .ent       (ent),
        .zero      (m_zero_norm)
    );

    assign m_m00 = ent[0];
    assign m_m01 = ent[1];
    assign m_m02 = ent[2];
    assign m_m10 = ent[3];
    assign m_m11 = ent[4];
    assign m_m12 = ent[5];
    assign m_m20 = ent[6];
    assign m_m21 = ent[7];
    assign m_m22 = ent[8];
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for the quaternion to rotation matrix block: directed and random quaternions.
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic signed [qrm_pkg::OUT_W-1:0] ent [9];
        logic                             zero;
    } matrix_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [qrm_pkg::IN_W-1:0] s_q_w = '0, s_q_x = '0, s_q_y = '0, s_q_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [qrm_pkg::OUT_W-1:0] m_m00, m_m01, m_m02, m_m10, m_m11, m_m12;
    logic signed [qrm_pkg::OUT_W-1:0] m_m20, m_m21, m_m22;
    logic m_zero_norm;

    matrix_t matrix_q[$];
    int      err_cnt = 0;
    longint  cyc = 0;
    int      burst_left = 0;

    always #5 aclk = ~aclk;

    quaternion_to_rotation_matrix dut (.*);

    // magnitude * 2^FRAC / den, rounded half away from zero, clamped to one
    function automatic longint scaled_quot(longint mag, longint den);
        longint q, r;
        q = (mag <<< qrm_pkg::FRAC_W) / den;
        r = (mag <<< qrm_pkg::FRAC_W) % den;
        if (2 * r >= den) q++;
        if (q > (64'sd1 <<< qrm_pkg::FRAC_W)) q = 64'sd1 <<< qrm_pkg::FRAC_W;
        return q;
    endfunction

    function automatic logic signed [qrm_pkg::OUT_W-1:0] entry(longint num, longint den);
        longint q;
        q = scaled_quot(num < 0 ? -num : num, den);
        return (num < 0) ? qrm_pkg::OUT_W'(-q) : qrm_pkg::OUT_W'(q);
    endfunction

    function automatic matrix_t rotation_of(logic signed [qrm_pkg::IN_W-1:0] qw, qx, qy, qz);
        matrix_t m;
        longint w, x, y, z, n2;
        w = qw; x = qx; y = qy; z = qz;
        m.zero = (w == 0 && x == 0 && y == 0 && z == 0);
        if (m.zero) begin
            foreach (m.ent[i]) m.ent[i] = '0;
            return m;
        end
        n2 = w*w + x*x + y*y + z*z;
        // a norm of 2^NUM_W or more is mapped to the all -1 rotation; 16-bit inputs stay below it
        if (n2 >= (64'sd1 <<< qrm_pkg::NUM_W)) begin
            w = -1; x = -1; y = -1; z = -1; n2 = 4;
        end
        m.ent[0] = entry(w*w + x*x - y*y - z*z, n2);
        m.ent[1] = entry(2 * (x*y - w*z), n2);
        m.ent[2] = entry(2 * (x*z + w*y), n2);
        m.ent[3] = entry(2 * (x*y + w*z), n2);
        m.ent[4] = entry(w*w - x*x + y*y - z*z, n2);
        m.ent[5] = entry(2 * (y*z - w*x), n2);
        m.ent[6] = entry(2 * (x*z - w*y), n2);
        m.ent[7] = entry(2 * (y*z + w*x), n2);
        m.ent[8] = entry(w*w - x*x - y*y + z*z, n2);
        return m;
    endfunction

    // send one quaternion beat, bursts with random gaps
    task automatic send_quat(logic signed [qrm_pkg::IN_W-1:0] qw, qx, qy, qz);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_q_w <= qw; s_q_x <= qx; s_q_y <= qy; s_q_z <= qz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        matrix_q.insert(matrix_q.size(), rotation_of(qw, qx, qy, qz));
    endtask

    task automatic drain_wait();
        s_valid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    // receiver stall pattern: runs of full acceptance, mostly-ready runs and mostly-stalled runs
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        case ((cyc >> 7) % 3)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (cyc > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        logic signed [qrm_pkg::OUT_W-1:0] got [9];
        matrix_t exp_m;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_m00, m_m01, m_m02, m_m10, m_m11, m_m12, m_m20, m_m21, m_m22};
            if (matrix_q.size() == 0) begin
                $display("%0t unexpected result beat", $time);
                err_cnt++;
            end else begin
                exp_m = matrix_q.pop_front();
                foreach (got[i])
                    if (got[i] !== exp_m.ent[i]) begin
                        $display("%0t entry %0d exp %0d got %0d", $time, i, exp_m.ent[i],
                                 got[i]);
                        err_cnt++;
                    end
                if (m_zero_norm !== exp_m.zero) begin
                    $display("%0t zero_norm exp %0b got %0b", $time, exp_m.zero,
                             m_zero_norm);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_extremes();
        logic signed [qrm_pkg::IN_W-1:0] v [5] = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd1,
                                                   -16'sd1};
        send_quat(0, 0, 0, 0);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sh8000, 0, 0, 0);
        send_quat(0, 16'sh8000, 0, 0);
        send_quat(0, 0, 16'sh7fff, 0);
        send_quat(0, 0, 0, -16'sd1);
        send_quat(1, 1, 0, 0);
        send_quat(3, 0, 0, 0);
        send_quat(1, 2, 3, 4);
        send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        for (int i = 0; i < 10; i++)
            send_quat(v[$urandom_range(0, 4)], v[$urandom_range(0, 4)],
                      v[$urandom_range(0, 4)], v[$urandom_range(0, 4)]);
    endtask

    task automatic test_random();
        for (int i = 0; i < 1900; i++) begin
            int sh;
            sh = $urandom_range(0, 15);
            if (i % 100 == 0) send_quat(0, 0, 0, 0);
            else send_quat($signed(16'($urandom)) >>> sh, $signed(16'($urandom)) >>> sh,
                           $signed(16'($urandom)) >>> sh, $signed(16'($urandom)) >>> sh);
            if (i == 950) drain_wait();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        drain_wait();
        test_random();
        drain_wait();
        if (err_cnt == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
